>>> rtl/mf3_pkg.sv
// Shared types and constants for the interleaved 3x3 median filter.
// No dependencies; used by median_3x3_interleaved_core.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int ROWS_W       = 16;
  localparam int LINE_BYTES_W = 14;
  localparam int COMP_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd2;

  localparam logic [LINE_BYTES_W-1:0] RST_LINE_BYTES = 14'd1920;
  localparam logic [COMP_W-1:0]       RST_COMPONENTS = 3'd3;
  localparam logic [ROWS_W-1:0]       RST_IMAGE_ROWS = 16'd480;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;

  typedef logic [SAMPLE_W-1:0] pix_t;

  // one vertical slice of the window: rows r-1, r, r+1
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic last;
    pix_t median;
  } res_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

>>> rtl/median_3x3_interleaved_core.sv
// Streaming 3x3 median filter over interleaved image bytes.
// Depends on mf3_pkg (types, register indexes, compare helpers).
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready, kind, sample): image bytes in raster
//   order, then flush ticks (kind = 1) to drive out the trailing results.
//   Output channel (out_valid/out_ready, median, last): one median per image
//   byte, last marks the final byte of the frame.
//   Config port (cfg_write, cfg_index, cfg_data): line_bytes, components,
//   image_rows; write only while the block is idle.
//   Throughput is one item per clock while in_ready is high. The two line
//   stores share one single-port-read memory of {row-2,row-1} byte pairs
//   read at accept and written back in the next cycle, with one forwarding
//   register for short rows. The result for a centre byte leaves with the
//   item that arrives one row plus one pixel later, through registered
//   stages s1 to s5 and the result queue.
//   Frames of fewer than one row plus one pixel of bytes: after the last
//   byte, in_ready stays low while the window is advanced over padding.
//   Reset clears counters and restores register defaults; line stores are
//   not cleared. When the receiver stalls, up to 8 results queue; in_ready
//   drops once 8 results are pending.
module median_3x3_interleaved_core #(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [mf3_pkg::SAMPLE_W-1:0]      sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mf3_pkg::SAMPLE_W-1:0]      median,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam int LW = AW + 1;
  localparam int PW = AW + 2;
  localparam int WD = 2 * MAX_COMPONENTS + 1;
  localparam int RW = mf3_pkg::ROWS_W;
  localparam int FD = mf3_pkg::OUT_DEPTH;
  localparam int FA = mf3_pkg::OUT_AW;

  // configuration
  logic [mf3_pkg::LINE_BYTES_W-1:0] line_bytes;
  logic [mf3_pkg::COMP_W-1:0]       components;
  logic [RW-1:0]                    image_rows;

  logic [LW-1:0] len_eff;
  logic [2:0]    comp_eff;
  logic [RW-1:0] rows_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= mf3_pkg::RST_LINE_BYTES;
      components <= mf3_pkg::RST_COMPONENTS;
      image_rows <= mf3_pkg::RST_IMAGE_ROWS;
    end else if (cfg_write) begin
      case (cfg_index)
        mf3_pkg::REG_LINE_BYTES: line_bytes <= cfg_data[mf3_pkg::LINE_BYTES_W-1:0];
        mf3_pkg::REG_COMPONENTS: components <= cfg_data[mf3_pkg::COMP_W-1:0];
        mf3_pkg::REG_IMAGE_ROWS: image_rows <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_bytes == '0)
      len_eff = LW'(1);
    else if (32'(line_bytes) > 32'(MAX_LINE_BYTES))
      len_eff = LW'(MAX_LINE_BYTES);
    else
      len_eff = LW'(line_bytes);
    if (components == '0)
      comp_eff = 3'd1;
    else if (32'(components) > 32'(MAX_COMPONENTS))
      comp_eff = 3'(MAX_COMPONENTS);
    else
      comp_eff = components;
    rows_eff = (image_rows == '0) ? RW'(1) : image_rows;
  end

  // position counters
  logic [AW-1:0]   in_col, in_col_next;
  logic [RW:0]     in_row, in_row_next;
  logic [AW-1:0]   out_col, out_col_next;
  logic [RW-1:0]   out_row, out_row_next;
  logic [PW-1:0]   prime, prime_next;
  logic            pad, pad_next;
  logic [FA:0]     occ, occ_next;

  logic            in_xfer, out_xfer;
  logic            frame_done, pending, primed;
  logic [PW-1:0]   lc, prime_adv;
  logic            push0, emit0, last0;
  mf3_pkg::pix_t   sample0;
  logic            in_wrap, out_wrap;
  logic [AW-1:0]   in_col_adv;
  logic [RW:0]     in_row_adv;

  assign in_ready = !pad && (occ < (FA+1)'(FD));
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    frame_done = in_row >= {1'b0, rows_eff};
    pending    = out_row < rows_eff;
    lc         = PW'(len_eff) + PW'(comp_eff);
    primed     = prime >= lc;
    prime_adv  = primed ? prime : prime + PW'(1);

    in_wrap    = ({1'b0, in_col} + LW'(1)) == len_eff;
    in_col_adv = in_wrap ? '0 : in_col + AW'(1);
    in_row_adv = in_row + (RW+1)'(in_wrap);
    out_wrap   = ({1'b0, out_col} + LW'(1)) == len_eff;

    push0   = 1'b0;
    emit0   = 1'b0;
    sample0 = '0;
    if (pad) begin
      push0 = 1'b1;
    end else if (in_xfer) begin
      if (frame_done) begin
        // past the frame: while results are pending, every item pushes padding and reports one centre
        push0 = pending;
        emit0 = pending;
      end else if (kind == mf3_pkg::KIND_BYTE) begin
        push0   = 1'b1;
        emit0   = primed && pending;
        sample0 = sample;
      end
    end
    last0 = emit0 && out_wrap && ((RW+1)'(out_row) + (RW+1)'(1) >= (RW+1)'(rows_eff));

    in_col_next  = in_col;
    in_row_next  = in_row;
    prime_next   = prime;
    out_col_next = out_col;
    out_row_next = out_row;
    pad_next     = pad;
    if (push0) begin
      in_col_next = in_col_adv;
      in_row_next = in_row_adv;
      prime_next  = prime_adv;
    end
    if (emit0) begin
      out_col_next = out_wrap ? '0 : out_col + AW'(1);
      out_row_next = out_row + RW'(out_wrap);
    end
    if (pad)
      pad_next = prime_adv < lc;
    else if (push0 && !frame_done)
      pad_next = (in_row_adv >= {1'b0, rows_eff}) && (prime_adv < lc);
    if (last0 || (in_xfer && frame_done && !pending)) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
      prime_next   = '0;
      pad_next     = 1'b0;
    end
    occ_next = occ + (FA+1)'(emit0) - (FA+1)'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      prime   <= '0;
      pad     <= 1'b0;
      occ     <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      prime   <= prime_next;
      pad     <= pad_next;
      occ     <= occ_next;
    end
  end

  // line store: {row-2, row-1} per column
  logic [2*mf3_pkg::SAMPLE_W-1:0] line_mem [MAX_LINE_BYTES];
  logic [2*mf3_pkg::SAMPLE_W-1:0] rd_q, fwd_data, stored, wdata;
  logic                           fwd_hit;

  logic            s1_valid, s1_emit, s1_last;
  logic [AW-1:0]   s1_addr, s1_qc;
  logic [RW-1:0]   s1_qr;
  mf3_pkg::pix_t   s1_sample;
  mf3_pkg::col_t   col1;
  mf3_pkg::col_t   win [WD];

  always_comb begin
    stored   = fwd_hit ? fwd_data : rd_q;
    col1.top = stored[2*mf3_pkg::SAMPLE_W-1:mf3_pkg::SAMPLE_W];
    col1.mid = stored[mf3_pkg::SAMPLE_W-1:0];
    col1.bot = s1_sample;
    wdata    = {col1.mid, s1_sample};
  end

  always_ff @(posedge clk) begin
    if (push0)
      rd_q <= line_mem[in_col];
    if (s1_valid)
      line_mem[s1_addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    // the previous push writes this column in the cycle it is read
    fwd_hit   <= s1_valid && (s1_addr == in_col);
    fwd_data  <= wdata;
    s1_addr   <= in_col;
    s1_sample <= sample0;
    s1_emit   <= emit0;
    s1_last   <= last0;
    s1_qr     <= out_row;
    s1_qc     <= out_col;
    if (s1_valid) begin
      win[0] <= col1;
      for (int k = 1; k < WD; k++)
        win[k] <= win[k-1];
    end
  end

  // window taps and border zeroing
  logic            s2_valid, s2_last;
  logic [AW-1:0]   s2_qc;
  logic [RW-1:0]   s2_qr;
  mf3_pkg::col_t   tap_l, tap_m, tap_r;
  mf3_pkg::col_t   m_l, m_m, m_r;
  logic            top_ok, bot_ok, left_ok, right_ok;

  always_comb begin
    tap_l = win[2];
    tap_m = win[1];
    for (int k = 1; k <= MAX_COMPONENTS; k++) begin
      if (comp_eff == 3'(k)) begin
        tap_l = win[2*k];
        tap_m = win[k];
      end
    end
    tap_r    = win[0];
    top_ok   = s2_qr != '0;
    bot_ok   = ((RW+1)'(s2_qr) + (RW+1)'(1)) < (RW+1)'(rows_eff);
    left_ok  = {1'b0, s2_qc} >= LW'(comp_eff);
    right_ok = (PW'(s2_qc) + PW'(comp_eff)) < PW'(len_eff);
    m_l = tap_l;
    m_m = tap_m;
    m_r = tap_r;
    if (!top_ok) begin
      m_l.top = '0;
      m_m.top = '0;
      m_r.top = '0;
    end
    if (!bot_ok) begin
      m_l.bot = '0;
      m_m.bot = '0;
      m_r.bot = '0;
    end
    if (!left_ok)
      m_l = '0;
    if (!right_ok)
      m_r = '0;
  end

  // median: sort columns, then max of mins, median of medians, min of maxes
  logic            s3_valid, s3_last, s4_valid, s4_last, s5_valid, s5_last;
  mf3_pkg::col_t   v3 [3];
  mf3_pkg::pix_t   mn4 [3], md4 [3], mx4 [3];
  mf3_pkg::pix_t   lo5, mid5, hi5;

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    s2_qr   <= s1_qr;
    s2_qc   <= s1_qc;
    v3[0]   <= m_l;
    v3[1]   <= m_m;
    v3[2]   <= m_r;
    s3_last <= s2_last;
    for (int i = 0; i < 3; i++) begin
      mn4[i] <= mf3_pkg::min2(mf3_pkg::min2(v3[i].top, v3[i].mid), v3[i].bot);
      md4[i] <= mf3_pkg::med3(v3[i].top, v3[i].mid, v3[i].bot);
      mx4[i] <= mf3_pkg::max2(mf3_pkg::max2(v3[i].top, v3[i].mid), v3[i].bot);
    end
    s4_last <= s3_last;
    lo5     <= mf3_pkg::max2(mf3_pkg::max2(mn4[0], mn4[1]), mn4[2]);
    mid5    <= mf3_pkg::med3(md4[0], md4[1], md4[2]);
    hi5     <= mf3_pkg::min2(mf3_pkg::min2(mx4[0], mx4[1]), mx4[2]);
    s5_last <= s4_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= push0;
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // result queue; occ keeps it from overflowing
  mf3_pkg::res_t  res_q [FD];
  mf3_pkg::res_t  res_in;
  logic [FA-1:0]  wr_ptr, rd_ptr;
  logic [FA:0]    q_count;

  assign res_in    = '{last: s5_last, median: mf3_pkg::med3(lo5, mid5, hi5)};
  assign out_valid = q_count != '0;
  assign out_xfer  = out_valid && out_ready;
  assign median    = res_q[rd_ptr].median;
  assign last      = res_q[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (s5_valid)
      res_q[wr_ptr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s5_valid)
        wr_ptr <= wr_ptr + FA'(1);
      if (out_xfer)
        rd_ptr <= rd_ptr + FA'(1);
      q_count <= q_count + (FA+1)'(s5_valid) - (FA+1)'(out_xfer);
    end
  end

endmodule

>>> test/median_3x3_interleaved_core_tb.sv
// Self-checking testbench for median_3x3_interleaved_core: directed table, then fixed and random frames.
// Depends on mf3_pkg and the core; a local predictor builds the expected medians.
`timescale 1ns / 1ps

module median_3x3_interleaved_core_tb;

  localparam int MAXLB   = 8192;
  localparam int MAXC    = 4;
  localparam int WIN_LEN = 2 * MAXLB + 2 * MAXC + 1;
  localparam int STALL_LIMIT = 20000;
  localparam int DW      = mf3_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic kind = mf3_pkg::KIND_BYTE;
  mf3_pkg::pix_t sample = '0;
  logic out_valid, out_ready = 1'b0;
  mf3_pkg::pix_t median;
  logic last;
  logic cfg_write = 1'b0;
  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index = mf3_pkg::REG_LINE_BYTES;
  logic [DW-1:0] cfg_data = '0;

  median_3x3_interleaved_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [mf3_pkg::LINE_BYTES_W-1:0] p_len_raw;
  logic [mf3_pkg::COMP_W-1:0]       p_comp_raw;
  logic [mf3_pkg::ROWS_W-1:0]       p_rows_raw;
  mf3_pkg::pix_t                    hist [WIN_LEN];
  int unsigned in_col, in_row, out_col, out_row;

  mf3_pkg::res_t pending_medians [$];
  int unsigned errors, n_items, n_results, n_frames;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  function automatic int unsigned eff_len();
    if (p_len_raw == 0) return 1;
    if (p_len_raw > MAXLB) return MAXLB;
    return 32'(p_len_raw);
  endfunction

  function automatic int unsigned eff_comp();
    if (p_comp_raw == 0) return 1;
    if (p_comp_raw > MAXC) return MAXC;
    return 32'(p_comp_raw);
  endfunction

  function automatic int unsigned eff_rows();
    return (p_rows_raw == 0) ? 1 : 32'(p_rows_raw);
  endfunction

  function automatic mf3_pkg::pix_t window_at(longint r, longint c, int unsigned len,
                                              int unsigned rows);
    if (r < 0 || c < 0 || r >= rows || c >= len) return '0;
    return hist[(r * len + c) % WIN_LEN];
  endfunction

  // median of the centre at out_row/out_col, then advance the output position
  function automatic mf3_pkg::res_t next_median(int unsigned len, int unsigned comp,
                                                int unsigned rows);
    mf3_pkg::pix_t v [9];
    mf3_pkg::pix_t t;
    int n, k;
    mf3_pkg::res_t r;
    n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++) begin
        t = window_at(longint'(out_row) + dr, longint'(out_col) + dc * longint'(comp),
                      len, rows);
        k = n;
        while (k > 0 && v[k-1] > t) begin
          v[k] = v[k-1];
          k--;
        end
        v[k] = t;
        n++;
      end
    r.median = v[4];
    r.last = 1'b0;
    out_col++;
    if (out_col >= len) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= rows) begin
      r.last = 1'b1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    return r;
  endfunction

  function automatic bit filter_step(logic k, mf3_pkg::pix_t s, output mf3_pkg::res_t r);
    int unsigned len, comp, rows;
    longint unsigned lin;
    len = eff_len(); comp = eff_comp(); rows = eff_rows();
    if (in_col >= len) begin
      in_col = 0;
      if (in_row < rows) in_row++;
    end
    if (in_row >= rows) begin
      if (out_row < rows) begin
        r = next_median(len, comp, rows);
        return 1'b1;
      end
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      return 1'b0;
    end
    if (k == mf3_pkg::KIND_FLUSH) return 1'b0;
    lin = longint'(in_row) * len + in_col;
    hist[lin % WIN_LEN] = s;
    in_col++;
    if (in_col >= len) begin
      in_col = 0;
      in_row++;
    end
    if (lin >= len + comp && out_row < rows) begin
      r = next_median(len, comp, rows);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // one input transfer; called and returns at a falling edge with valid left high
  task automatic send(logic k, mf3_pkg::pix_t s, bit typed = 0,
                      mf3_pkg::res_t typed_res = '0);
    int gap;
    mf3_pkg::res_t r;
    gap = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (filter_step(k, s, r)) pending_medians.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // registers change only once the block has drained
  task automatic write_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      mf3_pkg::REG_LINE_BYTES: p_len_raw = val[mf3_pkg::LINE_BYTES_W-1:0];
      mf3_pkg::REG_COMPONENTS: p_comp_raw = val[mf3_pkg::COMP_W-1:0];
      mf3_pkg::REG_IMAGE_ROWS: p_rows_raw = val[mf3_pkg::ROWS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic mf3_pkg::pix_t rand_pix();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return mf3_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // a whole frame under the current settings, with stray flushes inside when noisy
  task automatic run_frame(bit noisy);
    int unsigned total, tail;
    total = eff_len() * eff_rows();
    tail = (total < eff_len() + eff_comp()) ? total : eff_len() + eff_comp();
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send(mf3_pkg::KIND_FLUSH, rand_pix());
      send(mf3_pkg::KIND_BYTE, rand_pix());
    end
    // a byte after the frame drains just like a flush tick
    for (int unsigned i = 0; i < tail; i++)
      send($urandom_range(0, 3) == 0 ? mf3_pkg::KIND_BYTE : mf3_pkg::KIND_FLUSH,
           rand_pix());
    if (noisy && $urandom_range(0, 3) == 0) send(mf3_pkg::KIND_FLUSH, rand_pix());
    n_frames++;
  endtask

  task automatic config_frame(int lb, int cp, int rw);
    write_reg(mf3_pkg::REG_LINE_BYTES, DW'(lb));
    write_reg(mf3_pkg::REG_COMPONENTS, DW'(cp));
    write_reg(mf3_pkg::REG_IMAGE_ROWS, DW'(rw));
  endtask

  typedef struct {
    bit   is_cfg;
    logic [mf3_pkg::CFG_IDX_W-1:0] idx;
    logic [DW-1:0] val;
    logic k;
    mf3_pkg::pix_t s;
    bit   typed;
    mf3_pkg::res_t exp;
  } step_t;

  step_t directed [$];

  function automatic step_t row_cfg(logic [mf3_pkg::CFG_IDX_W-1:0] idx, int val);
    step_t t;
    t = '{1'b1, idx, DW'(val), mf3_pkg::KIND_BYTE, '0, 1'b0, '0};
    return t;
  endfunction

  function automatic step_t row_item(logic k, mf3_pkg::pix_t s, bit typed = 0,
                                     mf3_pkg::res_t e = '0);
    step_t t;
    t = '{1'b0, mf3_pkg::REG_LINE_BYTES, '0, k, s, typed, e};
    return t;
  endfunction

  // receiver: random stall bursts, plus one long hold-off on request
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mf3_pkg::res_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("unexpected result median=%0d last=%0b", median, last));
      end else begin
        e = pending_medians.pop_front();
        if (median !== e.median)
          report_mismatch($sformatf("median %0d, want %0d", median, e.median));
        if (last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", last, e.last));
      end
    end
  end

  int unsigned quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mf3_pkg::res_t zl;
    zl.median = 8'h00;
    zl.last = 1'b1;
    p_len_raw = mf3_pkg::RST_LINE_BYTES;
    p_comp_raw = mf3_pkg::RST_COMPONENTS;
    p_rows_raw = mf3_pkg::RST_IMAGE_ROWS;
    for (int i = 0; i < WIN_LEN; i++) hist[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;

    // one-byte frame: eight zero pads outvote the byte
    directed.push_back(row_cfg(mf3_pkg::REG_LINE_BYTES, 1));
    directed.push_back(row_cfg(mf3_pkg::REG_COMPONENTS, 1));
    directed.push_back(row_cfg(mf3_pkg::REG_IMAGE_ROWS, 1));
    // flush inside a frame: ignored
    directed.push_back(row_item(mf3_pkg::KIND_FLUSH, 8'hFF));
    directed.push_back(row_item(mf3_pkg::KIND_BYTE, 8'hFF));
    directed.push_back(row_item(mf3_pkg::KIND_FLUSH, 8'h00, 1, zl));
    directed.push_back(row_item(mf3_pkg::KIND_BYTE, 8'h00));
    // byte past the frame drains
    directed.push_back(row_item(mf3_pkg::KIND_BYTE, 8'hFF, 1, zl));
    directed.push_back(row_cfg(mf3_pkg::REG_LINE_BYTES, 3));
    directed.push_back(row_cfg(mf3_pkg::REG_IMAGE_ROWS, 3));
    for (int i = 0; i < 9; i++)
      directed.push_back(row_item(mf3_pkg::KIND_BYTE, (i == 4) ? 8'h00 : 8'hFF));
    for (int i = 0; i < 4; i++) directed.push_back(row_item(mf3_pkg::KIND_FLUSH, 8'h00));

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].val);
      else send(directed[i].k, directed[i].s, directed[i].typed, directed[i].exp);
    end

    // receiver holds off while a wide frame keeps coming, so the queue fills up
    config_frame(16, 2, 6);
    hold_req = 1'b1;
    run_frame(1);

    // extremes: oversize component count, zero settings, a tall narrow image
    config_frame(12, 7, 4);
    run_frame(0);
    config_frame(0, 0, 0);
    run_frame(1);
    config_frame(2, 4, 150);
    run_frame(0);

    while (n_items < 1450) begin
      config_frame($urandom_range(0, 24), $urandom_range(0, 7), $urandom_range(0, 8));
      run_frame(1);
    end

    idle_en = 1'b0;
    for (int i = 0; i < 6; i++) begin
      config_frame($urandom_range(1, 20), $urandom_range(1, 4), $urandom_range(1, 6));
      run_frame(0);
    end

    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("tb: %0d frames, %0d items sent, %0d medians checked, %0d errors",
             n_frames, n_items, n_results, errors);
    $display("tb: settings swept from zero to past the component limit, stalls on both sides");
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
